// File: src/ptrs_pkg.sv
// Package for the pulse trigger rearm supervisor: field widths, register
// indexes, width unit codes, guard constants and the trigger second function.
// No dependencies.
`default_nettype none
package ptrs_pkg;

  localparam int TICK_W   = 32;
  localparam int SEC_W    = 32;
  localparam int NS_W     = 30;
  localparam int CNT_W    = 14;
  localparam int UNIT_W   = 2;
  localparam int TMO_W    = 16;
  localparam int OFS_W    = 8;
  localparam int EN_W     = 2;
  localparam int GUARD_W  = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REARM_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_GUARD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_COUNT_A  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_UNIT_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_COUNT_B  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_UNIT_B   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_OFFSET  = 3'd7;

  // register reset values
  localparam logic [TMO_W-1:0]  RST_REARM_TIMEOUT = 16'd2000;
  localparam logic [TMO_W-1:0]  RST_RESTART_GUARD = 16'd3000;
  localparam logic [EN_W-1:0]   RST_CHANNEL_EN    = 2'd1;
  localparam logic [CNT_W-1:0]  RST_WIDTH_COUNT   = 14'd2;
  localparam logic [UNIT_W-1:0] RST_WIDTH_UNIT    = 2'd2;
  localparam logic [OFS_W-1:0]  RST_SECOND_OFFSET = 8'd1;

  // width unit codes
  localparam logic [UNIT_W-1:0] UNIT_120NS  = 2'd0;
  localparam logic [UNIT_W-1:0] UNIT_1US    = 2'd1;
  localparam logic [UNIT_W-1:0] UNIT_1MS    = 2'd2;
  localparam logic [UNIT_W-1:0] UNIT_1US_B  = 2'd3;

  // op codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // 120 ns units: count*120 fits in 1 ms up to this count, else 2 ms
  localparam logic [CNT_W-1:0] CNT_120NS_ONE_MS = 14'd8333;
  // ceil(us/1000) via reciprocal: floor(x/1000) = (x*RECIP_1000) >> RECIP_SHIFT
  localparam int US_X_W      = 15;
  localparam int RECIP_SHIFT = 24;
  localparam logic [US_X_W-1:0] RECIP_1000 = 15'd16778;
  localparam logic [US_X_W-1:0] US_ROUND   = 15'd999;

  localparam logic [NS_W-1:0] HALF_SECOND_NS = 30'd500000000;

  function automatic logic [SEC_W-1:0] trig_sec(input logic [SEC_W-1:0] sec,
                                                input logic [NS_W-1:0] ns,
                                                input logic [OFS_W-1:0] ofs);
    logic [SEC_W-1:0] t;
    t = sec + {{(SEC_W-OFS_W){1'b0}}, ofs};
    if (ns >= HALF_SECOND_NS) begin
      t = t + 32'd1;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// File: src/ptrs_in_if.sv
// Input channel interface: valid/ready handshake plus the tick item payload.
// Depends on ptrs_pkg for field widths.
`default_nettype none
interface ptrs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [ptrs_pkg::TICK_W-1:0] tick_ms;
  logic                        clock_restarted;
  logic                        done_a;
  logic                        done_b;
  logic [ptrs_pkg::SEC_W-1:0]  ptp_seconds;
  logic [ptrs_pkg::NS_W-1:0]   ptp_nanos;

  modport source (output valid, op, tick_ms, clock_restarted, done_a, done_b,
                         ptp_seconds, ptp_nanos,
                  input  ready);
  modport sink   (input  valid, op, tick_ms, clock_restarted, done_a, done_b,
                         ptp_seconds, ptp_nanos,
                  output ready);
endinterface
`default_nettype wire

// File: src/ptrs_out_if.sv
// Result channel interface: valid/ready handshake plus clear/arm payload.
// Depends on ptrs_pkg for field widths.
`default_nettype none
interface ptrs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       clear_a;
  logic                       clear_b;
  logic                       arm_a;
  logic                       arm_b;
  logic [ptrs_pkg::SEC_W-1:0] trigger_sec_a;
  logic [ptrs_pkg::SEC_W-1:0] trigger_sec_b;

  modport source (output valid, clear_a, clear_b, arm_a, arm_b,
                         trigger_sec_a, trigger_sec_b,
                  input  ready);
  modport sink   (input  valid, clear_a, clear_b, arm_a, arm_b,
                         trigger_sec_a, trigger_sec_b,
                  output ready);
endinterface
`default_nettype wire

// File: src/ptrs_guard.sv
// Pending guard length: asserted pulse width rounded up to whole ms, plus 1.
// Depends on ptrs_pkg.
`default_nettype none
module ptrs_guard (
  input  wire logic [ptrs_pkg::CNT_W-1:0]   width_count,
  input  wire logic [ptrs_pkg::UNIT_W-1:0]  width_unit,
  output logic      [ptrs_pkg::GUARD_W-1:0] hold_ms
);
  import ptrs_pkg::*;

  logic [CNT_W-1:0]    cnt;
  logic [US_X_W-1:0]   us_x;
  logic [2*US_X_W-1:0] us_prod;
  logic [GUARD_W-1:0]  ms;

  assign cnt     = (width_count == '0) ? {{(CNT_W-1){1'b0}}, 1'b1} : width_count;
  assign us_x    = {1'b0, cnt} + US_ROUND;
  assign us_prod = us_x * RECIP_1000;

  always_comb begin
    unique case (width_unit)
      UNIT_1MS:             ms = {1'b0, cnt};
      UNIT_1US, UNIT_1US_B: ms = {{(GUARD_W-(2*US_X_W-RECIP_SHIFT)){1'b0}},
                                  us_prod[2*US_X_W-1:RECIP_SHIFT]};
      default:              ms = (cnt > CNT_120NS_ONE_MS) ? 15'd2 : 15'd1;
    endcase
  end

  assign hold_ms = ms + 15'd1;

endmodule
`default_nettype wire

// File: src/pulse_trigger_rearm_supervisor_core.sv
// Pulse trigger rearm supervisor, top level: config registers, input register,
// per-tick decision logic and result register. Depends on ptrs_pkg,
// ptrs_in_if, ptrs_out_if and ptrs_guard.
// Each input passes the input register, then the result register, to out_ch.
// Throughput: one transaction per cycle while out_ch is ready; both registers
// form a two-stage pipeline, so input is taken while a result waits.
// Reset (rst_n low, synchronous): config registers return to their defaults,
// supervisor state and both valid bits clear. No clearing pass is needed.
`default_nettype none
module pulse_trigger_rearm_supervisor_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  ptrs_in_if.sink                              in_ch,
  ptrs_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [ptrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ptrs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ptrs_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [TMO_W-1:0]  rearm_timeout_r;
  logic [TMO_W-1:0]  restart_guard_r;
  logic [EN_W-1:0]   chan_en_r;
  logic [CNT_W-1:0]  width_count_a_r;
  logic [UNIT_W-1:0] width_unit_a_r;
  logic [CNT_W-1:0]  width_count_b_r;
  logic [UNIT_W-1:0] width_unit_b_r;
  logic [OFS_W-1:0]  second_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rearm_timeout_r <= RST_REARM_TIMEOUT;
      restart_guard_r <= RST_RESTART_GUARD;
      chan_en_r       <= RST_CHANNEL_EN;
      width_count_a_r <= RST_WIDTH_COUNT;
      width_unit_a_r  <= RST_WIDTH_UNIT;
      width_count_b_r <= RST_WIDTH_COUNT;
      width_unit_b_r  <= RST_WIDTH_UNIT;
      second_offset_r <= RST_SECOND_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REARM_TIMEOUT:  rearm_timeout_r <= cfg_wdata;
        REG_RESTART_GUARD:  restart_guard_r <= cfg_wdata;
        REG_CHANNEL_ENABLE: chan_en_r       <= cfg_wdata[EN_W-1:0];
        REG_WIDTH_COUNT_A:  width_count_a_r <= cfg_wdata[CNT_W-1:0];
        REG_WIDTH_UNIT_A:   width_unit_a_r  <= cfg_wdata[UNIT_W-1:0];
        REG_WIDTH_COUNT_B:  width_count_b_r <= cfg_wdata[CNT_W-1:0];
        REG_WIDTH_UNIT_B:   width_unit_b_r  <= cfg_wdata[UNIT_W-1:0];
        REG_SECOND_OFFSET:  second_offset_r <= cfg_wdata[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control: stage 1 = input register, stage 2 = result register
  // ---------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic advance;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // input register payload
  logic              op_r;
  logic [TICK_W-1:0] tick_r;
  logic              restarted_r;
  logic              done_a_r;
  logic              done_b_r;
  logic [SEC_W-1:0]  sec_r;
  logic [NS_W-1:0]   ns_r;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r        <= in_ch.op;
      tick_r      <= in_ch.tick_ms;
      restarted_r <= in_ch.clock_restarted;
      done_a_r    <= in_ch.done_a;
      done_b_r    <= in_ch.done_b;
      sec_r       <= in_ch.ptp_seconds;
      ns_r        <= in_ch.ptp_nanos;
    end
  end

  // ---------------------------------------------------------------------
  // Supervisor state
  // ---------------------------------------------------------------------
  logic              started_r,   started_nxt;
  logic              pending_a_r, pending_a_nxt;
  logic              pending_b_r, pending_b_nxt;
  logic [TICK_W-1:0] done_time_a_r, done_time_a_nxt;
  logic [TICK_W-1:0] done_time_b_r, done_time_b_nxt;
  logic [TICK_W-1:0] arm_time_a_r,  arm_time_a_nxt;
  logic [TICK_W-1:0] arm_time_b_r,  arm_time_b_nxt;
  logic [TICK_W-1:0] restart_time_r, restart_time_nxt;

  // guard lengths straight from the width config
  logic [GUARD_W-1:0] guard_a;
  logic [GUARD_W-1:0] guard_b;

  ptrs_guard u_guard_a (
    .width_count (width_count_a_r),
    .width_unit  (width_unit_a_r),
    .hold_ms     (guard_a)
  );

  ptrs_guard u_guard_b (
    .width_count (width_count_b_r),
    .width_unit  (width_unit_b_r),
    .hold_ms     (guard_b)
  );

  // ---------------------------------------------------------------------
  // Per-tick decision logic
  // ---------------------------------------------------------------------
  logic [SEC_W-1:0]  tsec_now;
  logic              restart_ok;
  logic              clr_a, clr_b, arm_a, arm_b;
  logic              pend_a1, pend_b1;   // pending after done-flag check
  logic [TICK_W-1:0] dt_a, dt_b;         // effective done time
  logic              fire_a, fire_b;     // guard ended
  logic              tmo_a, tmo_b;       // timeout rearm

  assign tsec_now   = trig_sec(sec_r, ns_r, second_offset_r);
  assign restart_ok = (tick_r - restart_time_r) >= {{(TICK_W-TMO_W){1'b0}}, restart_guard_r};

  always_comb begin
    // channel A
    pend_a1 = pending_a_r || done_a_r;
    dt_a    = pending_a_r ? done_time_a_r : tick_r;
    fire_a  = pend_a1 && ((tick_r - dt_a) >= {{(TICK_W-GUARD_W){1'b0}}, guard_a});
    tmo_a   = !(pend_a1 && !fire_a) && !fire_a && restart_ok &&
              ((tick_r - arm_time_a_r) >= {{(TICK_W-TMO_W){1'b0}}, rearm_timeout_r});
    // channel B
    pend_b1 = pending_b_r || done_b_r;
    dt_b    = pending_b_r ? done_time_b_r : tick_r;
    fire_b  = pend_b1 && ((tick_r - dt_b) >= {{(TICK_W-GUARD_W){1'b0}}, guard_b});
    tmo_b   = !(pend_b1 && !fire_b) && !fire_b && restart_ok &&
              ((tick_r - arm_time_b_r) >= {{(TICK_W-TMO_W){1'b0}}, rearm_timeout_r});
  end

  always_comb begin
    started_nxt      = started_r;
    pending_a_nxt    = pending_a_r;
    pending_b_nxt    = pending_b_r;
    done_time_a_nxt  = done_time_a_r;
    done_time_b_nxt  = done_time_b_r;
    arm_time_a_nxt   = arm_time_a_r;
    arm_time_b_nxt   = arm_time_b_r;
    restart_time_nxt = restart_time_r;
    clr_a = 1'b0;
    clr_b = 1'b0;
    arm_a = 1'b0;
    arm_b = 1'b0;

    priority if (op_r == OP_START) begin
      // start: arm each enabled channel with timer base zero, flags ignored
      started_nxt = 1'b1;
      if (chan_en_r[0]) begin
        arm_a          = 1'b1;
        arm_time_a_nxt = '0;
        pending_a_nxt  = 1'b0;
      end
      if (chan_en_r[1]) begin
        arm_b          = 1'b1;
        arm_time_b_nxt = '0;
        pending_b_nxt  = 1'b0;
      end
    end else if (!started_r) begin
      // tick before start: nothing changes
    end else if (restarted_r) begin
      restart_time_nxt = tick_r;
      if (chan_en_r[0]) begin
        pending_a_nxt  = 1'b0;
        arm_time_a_nxt = tick_r;
      end
      if (chan_en_r[1]) begin
        pending_b_nxt  = 1'b0;
        arm_time_b_nxt = tick_r;
      end
    end else begin
      if (chan_en_r[0]) begin
        done_time_a_nxt = dt_a;
        pending_a_nxt   = pend_a1 && !fire_a;
        clr_a           = fire_a;
        arm_a           = fire_a || tmo_a;
        if (arm_a) begin
          arm_time_a_nxt = tick_r;
          pending_a_nxt  = 1'b0;
        end
      end
      if (chan_en_r[1]) begin
        done_time_b_nxt = dt_b;
        pending_b_nxt   = pend_b1 && !fire_b;
        clr_b           = fire_b;
        arm_b           = fire_b || tmo_b;
        if (arm_b) begin
          arm_time_b_nxt = tick_r;
          pending_b_nxt  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r      <= 1'b0;
      pending_a_r    <= 1'b0;
      pending_b_r    <= 1'b0;
      done_time_a_r  <= '0;
      done_time_b_r  <= '0;
      arm_time_a_r   <= '0;
      arm_time_b_r   <= '0;
      restart_time_r <= '0;
    end else if (advance) begin
      started_r      <= started_nxt;
      pending_a_r    <= pending_a_nxt;
      pending_b_r    <= pending_b_nxt;
      done_time_a_r  <= done_time_a_nxt;
      done_time_b_r  <= done_time_b_nxt;
      arm_time_a_r   <= arm_time_a_nxt;
      arm_time_b_r   <= arm_time_b_nxt;
      restart_time_r <= restart_time_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic             clear_a_r, clear_b_r, arm_a_r, arm_b_r;
  logic [SEC_W-1:0] tsec_a_r, tsec_b_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      clear_a_r <= clr_a;
      clear_b_r <= clr_b;
      arm_a_r   <= arm_a;
      arm_b_r   <= arm_b;
      // trigger second reads zero on an idle channel
      tsec_a_r  <= arm_a ? tsec_now : '0;
      tsec_b_r  <= arm_b ? tsec_now : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.clear_a       = clear_a_r;
  assign out_ch.clear_b       = clear_b_r;
  assign out_ch.arm_a         = arm_a_r;
  assign out_ch.arm_b         = arm_b_r;
  assign out_ch.trigger_sec_a = tsec_a_r;
  assign out_ch.trigger_sec_b = tsec_b_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_clear_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!clear_a_r || arm_a_r) && (!clear_b_r || arm_b_r)))
    else $error("clear request without rearm");

  a_idle_sec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((arm_a_r || tsec_a_r == '0) && (arm_b_r || tsec_b_r == '0)))
    else $error("trigger second nonzero on unarmed channel");

  a_start_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(advance && op_r == OP_START && chan_en_r[0]))
      |-> (!pending_a_r && started_r))
    else $error("start left channel A pending");

  a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(advance))
    else $error("result transaction appeared without a processed input");

endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for pulse_trigger_rearm_supervisor_core: a tracker class
// that predicts clear/arm results, plus tasks for the stimulus and the config port.
// Depends on ptrs_pkg, ptrs_in_if, ptrs_out_if and the core RTL.
package rearm_check_pkg;
  import ptrs_pkg::*;

  typedef struct packed {
    logic             op;
    logic [TICK_W-1:0] tick_ms;
    logic             clock_restarted;
    logic             done_a;
    logic             done_b;
    logic [SEC_W-1:0]  ptp_seconds;
    logic [NS_W-1:0]   ptp_nanos;
  } tick_txn_t;

  typedef struct packed {
    logic             clear_a;
    logic             clear_b;
    logic             arm_a;
    logic             arm_b;
    logic [SEC_W-1:0]  trigger_sec_a;
    logic [SEC_W-1:0]  trigger_sec_b;
  } arm_txn_t;

  // Mirrors the supervisor: register copies, channel state, expected results.
  class rearm_tracker;
    logic [TMO_W-1:0]  rearm_timeout;
    logic [TMO_W-1:0]  restart_guard;
    logic [EN_W-1:0]   chan_en;
    logic [CNT_W-1:0]  width_count [2];
    logic [UNIT_W-1:0] width_unit [2];
    logic [OFS_W-1:0]  trig_offset;

    logic              started;
    logic [1:0]        pending;
    logic [TICK_W-1:0] done_time [2];
    logic [TICK_W-1:0] arm_time [2];
    logic [TICK_W-1:0] restart_time;

    arm_txn_t          expected_arms [$];
    int                errors;

    function new();
      rearm_timeout  = RST_REARM_TIMEOUT;
      restart_guard  = RST_RESTART_GUARD;
      chan_en        = RST_CHANNEL_EN;
      width_count[0] = RST_WIDTH_COUNT;
      width_count[1] = RST_WIDTH_COUNT;
      width_unit[0]  = RST_WIDTH_UNIT;
      width_unit[1]  = RST_WIDTH_UNIT;
      trig_offset    = RST_SECOND_OFFSET;
      started        = 1'b0;
      pending        = '0;
      done_time[0]   = '0;
      done_time[1]   = '0;
      arm_time[0]    = '0;
      arm_time[1]    = '0;
      restart_time   = '0;
      errors         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_REARM_TIMEOUT:  rearm_timeout  = data[TMO_W-1:0];
        REG_RESTART_GUARD:  restart_guard  = data[TMO_W-1:0];
        REG_CHANNEL_ENABLE: chan_en        = data[EN_W-1:0];
        REG_WIDTH_COUNT_A:  width_count[0] = data[CNT_W-1:0];
        REG_WIDTH_UNIT_A:   width_unit[0]  = data[UNIT_W-1:0];
        REG_WIDTH_COUNT_B:  width_count[1] = data[CNT_W-1:0];
        REG_WIDTH_UNIT_B:   width_unit[1]  = data[UNIT_W-1:0];
        REG_SECOND_OFFSET:  trig_offset    = data[OFS_W-1:0];
        default: ;
      endcase
    endfunction

    // pulse width rounded up to whole ms, plus one
    function int unsigned guard_len(int ch);
      int unsigned cnt;
      int unsigned ms;
      cnt = (width_count[ch] == '0) ? 1 : int'(width_count[ch]);
      case (width_unit[ch])
        UNIT_1MS:             ms = cnt;
        UNIT_1US, UNIT_1US_B: ms = (cnt + 999) / 1000;
        default:              ms = (cnt * 120 + 999999) / 1000000;
      endcase
      return ms + 1;
    endfunction

    function logic [SEC_W-1:0] arm_second(logic [SEC_W-1:0] sec, logic [NS_W-1:0] ns);
      return sec + {{(SEC_W-OFS_W){1'b0}}, trig_offset} +
             ((ns >= HALF_SECOND_NS) ? 32'd1 : 32'd0);
    endfunction

    function void note_tick(tick_txn_t t);
      arm_txn_t          want;
      logic [1:0]        clr;
      logic [1:0]        arm;
      logic [1:0]        done;
      logic [SEC_W-1:0]  tsec [2];
      logic [TICK_W-1:0] now;
      logic [TICK_W-1:0] since_arm;
      logic [TICK_W-1:0] since_restart;
      logic [TICK_W-1:0] since_done;
      int                ch;
      clr     = '0;
      arm     = '0;
      done    = {t.done_b, t.done_a};
      tsec[0] = '0;
      tsec[1] = '0;
      now     = t.tick_ms;
      if (t.op == OP_START) begin
        for (ch = 0; ch < 2; ch++) begin
          if (chan_en[ch]) begin
            arm[ch]      = 1'b1;
            tsec[ch]     = arm_second(t.ptp_seconds, t.ptp_nanos);
            arm_time[ch] = '0;
            pending[ch]  = 1'b0;
          end
        end
        started = 1'b1;
      end else if (started) begin
        if (t.clock_restarted) begin
          restart_time = now;
          for (ch = 0; ch < 2; ch++) begin
            if (chan_en[ch]) begin
              pending[ch]  = 1'b0;
              arm_time[ch] = now;
            end
          end
        end else begin
          for (ch = 0; ch < 2; ch++) begin
            if (!chan_en[ch]) continue;
            if (!pending[ch] && done[ch]) begin
              pending[ch]   = 1'b1;
              done_time[ch] = now;
            end
            since_done = now - done_time[ch];
            if (pending[ch] && since_done >= guard_len(ch)) begin
              clr[ch]     = 1'b1;
              arm[ch]     = 1'b1;
              pending[ch] = 1'b0;
            end
          end
          since_restart = now - restart_time;
          for (ch = 0; ch < 2; ch++) begin
            since_arm = now - arm_time[ch];
            if (chan_en[ch] && !pending[ch] && !arm[ch] &&
                since_arm >= {16'd0, rearm_timeout} &&
                since_restart >= {16'd0, restart_guard}) begin
              arm[ch] = 1'b1;
            end
          end
          for (ch = 0; ch < 2; ch++) begin
            if (arm[ch]) begin
              tsec[ch]     = arm_second(t.ptp_seconds, t.ptp_nanos);
              arm_time[ch] = now;
              pending[ch]  = 1'b0;
            end
          end
        end
      end
      want.clear_a       = clr[0];
      want.clear_b       = clr[1];
      want.arm_a         = arm[0];
      want.arm_b         = arm[1];
      want.trigger_sec_a = tsec[0];
      want.trigger_sec_b = tsec[1];
      expected_arms.push_back(want);
    endfunction

    function void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_outcome(arm_txn_t got);
      arm_txn_t want;
      if (expected_arms.size() == 0) begin
        $error("result transaction with nothing expected: arm_a %0d arm_b %0d",
               got.arm_a, got.arm_b);
        errors++;
        return;
      end
      want = expected_arms.pop_front();
      match_field("clear_a", want.clear_a, got.clear_a);
      match_field("clear_b", want.clear_b, got.clear_b);
      match_field("arm_a", want.arm_a, got.arm_a);
      match_field("arm_b", want.arm_b, got.arm_b);
      match_field("trigger_sec_a", want.trigger_sec_a, got.trigger_sec_a);
      match_field("trigger_sec_b", want.trigger_sec_b, got.trigger_sec_b);
    endfunction
  endclass
endpackage

module tb;
  import ptrs_pkg::*;
  import rearm_check_pkg::*;

  localparam int CYCLE_LIMIT = 500000;  // run limit in clock cycles
  localparam int DRAIN_PAD   = 4;       // lets the pipeline empty, plus margin
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 120;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ptrs_in_if  in_ch ();
  ptrs_out_if out_ch ();

  rearm_tracker board;

  // idle/stall knobs, set by the stimulus process per phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // long receiver hold-off: requested by stimulus, counted by the sink
  int hold_request   = 0;
  int hold_left      = 0;
  int cycle_count;

  logic [CFG_DATA_W-1:0] reg_plan [8];

  pulse_trigger_rearm_supervisor_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic tick_txn_t make_tick(logic op, logic [TICK_W-1:0] tk, logic rs,
                                          logic da, logic db, logic [SEC_W-1:0] sec,
                                          logic [NS_W-1:0] ns);
    tick_txn_t t;
    t.op              = op;
    t.tick_ms         = tk;
    t.clock_restarted = rs;
    t.done_a          = da;
    t.done_b          = db;
    t.ptp_seconds     = sec;
    t.ptp_nanos       = ns;
    return t;
  endfunction

  // Mostly short counts for the ms unit so guards expire within a phase.
  function automatic logic [CFG_DATA_W-1:0] pick_count(logic [CFG_DATA_W-1:0] unit_word);
    if (unit_word[UNIT_W-1:0] == UNIT_1MS && $urandom_range(4) != 0) begin
      return CFG_DATA_W'($urandom_range(0, 12));
    end
    return CFG_DATA_W'($urandom);
  endfunction

  // Offer one input transaction; valid stays high across back-to-back items.
  task automatic offer_tick(input tick_txn_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.op              <= t.op;
    in_ch.tick_ms         <= t.tick_ms;
    in_ch.clock_restarted <= t.clock_restarted;
    in_ch.done_a          <= t.done_a;
    in_ch.done_b          <= t.done_b;
    in_ch.ptp_seconds     <= t.ptp_seconds;
    in_ch.ptp_nanos       <= t.ptp_nanos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_tick(t);
  endtask

  // Stop sending and wait for every expected result, then let the pipe empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.expected_arms.size() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Write all eight registers from reg_plan; only called with the block idle.
  task automatic program_regs();
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= reg_plan[i];
      @(posedge clk);
      board.set_reg(CFG_IDX_W'(i), reg_plan[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Result sink: checks each accepted transaction, drives ready per phase.
  initial begin : result_sink
    arm_txn_t got;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.clear_a       = out_ch.clear_a;
        got.clear_b       = out_ch.clear_b;
        got.arm_a         = out_ch.arm_a;
        got.arm_b         = out_ch.arm_b;
        got.trigger_sec_a = out_ch.trigger_sec_a;
        got.trigger_sec_b = out_ch.trigger_sec_b;
        board.check_outcome(got);
      end
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Run limit: a hang anywhere ends here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("pulse_trigger_rearm_supervisor_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    tick_txn_t         t;
    logic [TICK_W-1:0] now;
    logic [SEC_W-1:0]  sec;
    logic [NS_W-1:0]   ns;
    int                phase;
    int                n;
    int                pick;
    board = new();

    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= '0;
    cfg_wdata             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.op              <= OP_TICK;
    in_ch.tick_ms         <= '0;
    in_ch.clock_restarted <= 1'b0;
    in_ch.done_a          <= 1'b0;
    in_ch.done_b          <= 1'b0;
    in_ch.ptp_seconds     <= '0;
    in_ch.ptp_nanos       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, reset defaults: A only, 2000 ms timeout, 3000 ms guard,
    // 2 ms width (guard of 3 ticks), offset 1
    // ticks before any start: no effect, all-zero result, fields at extremes
    offer_tick(make_tick(OP_TICK, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
                         30'h3FFF_FFFF));
    offer_tick(make_tick(OP_TICK, 32'd0, 1'b0, 1'b0, 1'b0, 32'd0, 30'd0));
    // start ignores the flags; seconds wrap and the half-second rounds up
    offer_tick(make_tick(OP_START, 32'd0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF,
                         30'd500000000));
    // done flag opens the pending guard, cleared and rearmed 3 ticks later
    offer_tick(make_tick(OP_TICK, 32'd1, 1'b0, 1'b1, 1'b0, 32'd100, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd3, 1'b0, 1'b1, 1'b0, 32'd100, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd4, 1'b0, 1'b0, 1'b0, 32'd100, 30'd499999999));
    // clock restart wins over done and restarts the arm timer
    offer_tick(make_tick(OP_TICK, 32'd5, 1'b1, 1'b1, 1'b0, 32'd100, 30'd0));
    // timeout reached but the restart guard still holds the forced rearm
    offer_tick(make_tick(OP_TICK, 32'd2005, 1'b0, 1'b0, 1'b0, 32'd5, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd3005, 1'b0, 1'b0, 1'b0, 32'd7, 30'd999999999));
    // repeated start rearms at tick base zero
    offer_tick(make_tick(OP_START, 32'd77, 1'b0, 1'b0, 1'b1, 32'd8, 30'd0));
    settle();

    // zero timeout, no guard, both channels; masked upper bits on enable/offset;
    // A: 120 ns unit with count zero, B: us unit at the largest count
    reg_plan[REG_REARM_TIMEOUT]  = 16'd0;
    reg_plan[REG_RESTART_GUARD]  = 16'd0;
    reg_plan[REG_CHANNEL_ENABLE] = 16'hFFFF;
    reg_plan[REG_WIDTH_COUNT_A]  = 16'd0;
    reg_plan[REG_WIDTH_UNIT_A]   = {14'd0, UNIT_120NS};
    reg_plan[REG_WIDTH_COUNT_B]  = 16'h3FFF;
    reg_plan[REG_WIDTH_UNIT_B]   = {14'd0, UNIT_1US};
    reg_plan[REG_SECOND_OFFSET]  = 16'hFFFF;
    program_regs();
    offer_tick(make_tick(OP_START, 32'd0, 1'b0, 1'b0, 1'b0, 32'd1000, 30'd0));
    // both go pending right before the tick counter wraps
    offer_tick(make_tick(OP_TICK, 32'hFFFF_FFFE, 1'b0, 1'b1, 1'b1, 32'd1001, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 32'd1001, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd0, 1'b0, 1'b0, 1'b0, 32'd1002, 30'd600000000));
    offer_tick(make_tick(OP_TICK, 32'd1, 1'b0, 1'b0, 1'b0, 32'd1002, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd16, 1'b0, 1'b1, 1'b0, 32'd1003, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd17, 1'b1, 1'b1, 1'b1, 32'd1003, 30'd0));
    settle();

    // A disabled: its flags do nothing; B with the 120 ns rounding edge
    reg_plan[REG_REARM_TIMEOUT]  = 16'd5;
    reg_plan[REG_RESTART_GUARD]  = 16'd10;
    reg_plan[REG_CHANNEL_ENABLE] = 16'd2;
    reg_plan[REG_WIDTH_COUNT_A]  = 16'd1000;
    reg_plan[REG_WIDTH_UNIT_A]   = {14'd0, UNIT_1US_B};
    reg_plan[REG_WIDTH_COUNT_B]  = 16'd8334;
    reg_plan[REG_WIDTH_UNIT_B]   = {14'd0, UNIT_120NS};
    reg_plan[REG_SECOND_OFFSET]  = 16'd0;
    program_regs();
    offer_tick(make_tick(OP_START, 32'd0, 1'b0, 1'b0, 1'b0, 32'd50, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd1, 1'b0, 1'b1, 1'b1, 32'd50, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd4, 1'b0, 1'b1, 1'b0, 32'd51, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd20, 1'b0, 1'b0, 1'b0, 32'd52, 30'd0));
    offer_tick(make_tick(OP_TICK, 32'd27, 1'b0, 1'b0, 1'b0, 32'd53, 30'd0));
    settle();

    // ---- random part: one register setting and one idle mode per phase
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase

      if (phase == 0) begin
        // every register at its top value
        foreach (reg_plan[i]) reg_plan[i] = 16'hFFFF;
      end else if (phase == 1) begin
        reg_plan[REG_REARM_TIMEOUT]  = 16'd1;
        reg_plan[REG_RESTART_GUARD]  = 16'd0;
        reg_plan[REG_CHANNEL_ENABLE] = 16'd3;
        reg_plan[REG_WIDTH_COUNT_A]  = 16'd0;
        reg_plan[REG_WIDTH_UNIT_A]   = {14'd0, UNIT_120NS};
        reg_plan[REG_WIDTH_COUNT_B]  = 16'd0;
        reg_plan[REG_WIDTH_UNIT_B]   = {14'd0, UNIT_120NS};
        reg_plan[REG_SECOND_OFFSET]  = 16'd0;
      end else begin
        reg_plan[REG_REARM_TIMEOUT]  = ($urandom_range(9) == 0) ? 16'($urandom) :
                                       16'($urandom_range(0, 60));
        reg_plan[REG_RESTART_GUARD]  = ($urandom_range(9) == 0) ? 16'($urandom) :
                                       16'($urandom_range(0, 40));
        if (phase == 6) begin
          reg_plan[REG_CHANNEL_ENABLE] = 16'd0;
        end else if ($urandom_range(3) == 0) begin
          reg_plan[REG_CHANNEL_ENABLE] = {14'($urandom), 2'($urandom_range(1, 2))};
        end else begin
          reg_plan[REG_CHANNEL_ENABLE] = {14'($urandom), 2'd3};
        end
        reg_plan[REG_WIDTH_UNIT_A]   = 16'($urandom);
        reg_plan[REG_WIDTH_COUNT_A]  = pick_count(reg_plan[REG_WIDTH_UNIT_A]);
        reg_plan[REG_WIDTH_UNIT_B]   = 16'($urandom);
        reg_plan[REG_WIDTH_COUNT_B]  = pick_count(reg_plan[REG_WIDTH_UNIT_B]);
        reg_plan[REG_SECOND_OFFSET]  = 16'($urandom);
      end
      program_regs();

      // result side frozen for a long stretch while items keep coming
      if (phase == 4) hold_request = 300;

      now = (phase == 3) ? 32'hFFFF_FF00 : $urandom;
      sec = $urandom;
      offer_tick(make_tick(OP_START, now, 1'($urandom), 1'($urandom), 1'($urandom),
                           sec, 30'($urandom_range(0, 999999999))));

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // mostly small forward steps, some jumps past guards and timeouts,
        // a few jumps to an arbitrary tick value
        pick = $urandom_range(99);
        if (pick < 65)      now = now + $urandom_range(1, 3);
        else if (pick < 88) now = now + $urandom_range(4, 80);
        else if (pick < 97) now = now + $urandom_range(81, 70000);
        else                now = $urandom;
        if ($urandom_range(49) == 0)     sec = $urandom;
        else if ($urandom_range(3) == 0) sec = sec + 1;
        ns = ($urandom_range(9) == 0) ? 30'($urandom) : 30'($urandom_range(0, 999999999));
        t = make_tick(($urandom_range(99) < 2) ? OP_START : OP_TICK, now,
                      $urandom_range(99) < 4, $urandom_range(99) < 35,
                      $urandom_range(99) < 35, sec, ns);
        offer_tick(t);
        // sender waits out every pending result mid-phase
        if (phase == 5 && n == PHASE_ITEMS / 2) settle();
      end
      settle();
    end

    if (board.errors == 0 && board.expected_arms.size() == 0) begin
      $display("pulse_trigger_rearm_supervisor_core regression: pass");
    end else begin
      $display("pulse_trigger_rearm_supervisor_core regression: fail");
    end
    $finish;
  end
endmodule
